// ===== rtl/csw_pkg.sv =====
// ============================================================================
// csw_pkg
// Shared types, constants and digit helpers of the clock/stopwatch block.
// ============================================================================
package csw_pkg;

    localparam int TICK_W      = 20;
    localparam int REDRAW_W    = 24;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;
    localparam int IN_DATA_W   = 8;
    localparam int OUT_DATA_W  = 48;
    localparam int BTN_W       = 4;
    localparam int DIFF_W      = 38;
    localparam int TICK_MS_W   = 11;
    localparam int SUB_MS_W    = 10;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_PERIOD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_REDRAW = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SW_REDRAW    = 2'd2;

    localparam logic [TICK_W-1:0]   TICK_PERIOD_RESET  = 20'd10240;
    localparam logic [REDRAW_W-1:0] CLOCK_REDRAW_RESET = 24'd1000000;
    localparam logic [REDRAW_W-1:0] SW_REDRAW_RESET    = 24'd100000;
    localparam logic [TICK_MS_W-1:0] TICK_MS_RESET     = 11'd10;
    localparam logic [SUB_MS_W-1:0]  TICK_US_RESET     = 10'd240;

    // item kinds
    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_BUTTON = 1'b1;

    // button bits
    localparam int BTN_MODE = 0;
    localparam int BTN_RUN  = 1;
    localparam int BTN_NEXT = 2;
    localparam int BTN_INC  = 3;

    // cursor codes
    localparam logic [2:0] CUR_HOUR_TENS  = 3'd0;
    localparam logic [2:0] CUR_HOUR_UNITS = 3'd1;
    localparam logic [2:0] CUR_MIN_TENS   = 3'd2;
    localparam logic [2:0] CUR_MIN_UNITS  = 3'd3;
    localparam logic [2:0] CUR_SEC_TENS   = 3'd4;
    localparam logic [2:0] CUR_SEC_UNITS  = 3'd5;

    localparam logic [20:0] US_ONE_SEC = 21'd1000000;
    localparam logic [20:0] US_TWO_SEC = 21'd2000000;

    // floor(v / 1000) = (v * RECIP_1000) >> RECIP_SHIFT for any 20-bit v
    localparam int          RECIP_SHIFT = 30;
    localparam logic [20:0] RECIP_1000  = 21'd1073742;

    typedef struct packed {
        logic [TICK_W-1:0]    tick_period;
        logic [TICK_MS_W-1:0] tick_ms;
        logic [SUB_MS_W-1:0]  tick_us;
        logic [REDRAW_W-1:0]  clock_redraw;
        logic [REDRAW_W-1:0]  sw_redraw;
        logic                 busy;
    } csw_cfg_t;

    typedef struct packed {
        logic tick;
        logic toggle_run;
        logic clear;
    } csw_sw_ctrl_t;

    typedef struct packed {
        logic       running;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic [9:0] millis;
    } csw_sw_view_t;

    typedef struct packed {
        logic       mode;
        logic       clock_running;
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic [2:0] cursor;
        logic       redraw;
    } csw_clk_view_t;

    // result word, last field in the lowest bits
    typedef struct packed {
        logic [1:0] pad;
        logic       redraw;
        logic [2:0] cursor;
        logic [9:0] sw_millis;
        logic [5:0] sw_seconds;
        logic [5:0] sw_minutes;
        logic [5:0] seconds;
        logic [5:0] minutes;
        logic [4:0] hours;
        logic       stopwatch_running;
        logic       clock_running;
        logic       mode;
    } csw_result_t;

    function automatic logic at_nine(input logic [5:0] v);
        return (v == 6'd9) || (v == 6'd19) || (v == 6'd29) ||
               (v == 6'd39) || (v == 6'd49) || (v == 6'd59);
    endfunction

    function automatic logic [5:0] bump_tens(input logic [5:0] v, input logic [5:0] range);
        logic [6:0] sum;
        logic [6:0] wrapped;
        sum     = {1'b0, v} + 7'd10;
        wrapped = sum - {1'b0, range};
        return (sum >= {1'b0, range}) ? wrapped[5:0] : sum[5:0];
    endfunction

    function automatic logic [5:0] bump_units(input logic [5:0] v, input logic [5:0] range);
        logic [6:0] sum;
        sum = {1'b0, v} + 7'd1;
        if (at_nine(v))
            return v - 6'd9;
        return (sum >= {1'b0, range}) ? 6'd0 : sum[5:0];
    endfunction

endpackage

// ===== rtl/csw_cfg.sv =====
// ============================================================================
// csw_cfg
// Configuration registers; splits the tick period into ms and sub-ms parts.
// ============================================================================
module csw_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [csw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [csw_pkg::CFG_DATA_W-1:0]   cfg_data,
    output csw_pkg::csw_cfg_t                cfg
);

    logic [csw_pkg::TICK_W-1:0]    tick_period_reg;
    logic [csw_pkg::TICK_MS_W-1:0] tick_ms_reg;
    logic [csw_pkg::SUB_MS_W-1:0]  tick_us_reg;
    logic [csw_pkg::REDRAW_W-1:0]  clock_redraw_reg;
    logic [csw_pkg::REDRAW_W-1:0]  sw_redraw_reg;
    logic                          split_pend_reg;

    logic        wr;
    logic [40:0] recip_prod;
    logic [20:0] ms_scaled;
    logic [20:0] sub_ms;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid & cfg_ready;

    assign recip_prod = cfg_data[csw_pkg::TICK_W-1:0] * csw_pkg::RECIP_1000;
    assign ms_scaled  = {10'd0, tick_ms_reg} * 21'd1000;
    assign sub_ms     = {1'b0, tick_period_reg} - ms_scaled;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_period_reg  <= csw_pkg::TICK_PERIOD_RESET;
            tick_ms_reg      <= csw_pkg::TICK_MS_RESET;
            tick_us_reg      <= csw_pkg::TICK_US_RESET;
            clock_redraw_reg <= csw_pkg::CLOCK_REDRAW_RESET;
            sw_redraw_reg    <= csw_pkg::SW_REDRAW_RESET;
            split_pend_reg   <= 1'b0;
        end
        else
        begin
            // remainder settles in the cycle after the quotient
            tick_us_reg    <= sub_ms[csw_pkg::SUB_MS_W-1:0];
            split_pend_reg <= wr && (cfg_index == csw_pkg::CFG_TICK_PERIOD);
            if (wr)
            begin
                case (cfg_index)
                    csw_pkg::CFG_TICK_PERIOD:
                    begin
                        tick_period_reg <= cfg_data[csw_pkg::TICK_W-1:0];
                        tick_ms_reg     <= recip_prod[csw_pkg::RECIP_SHIFT +:
                                                      csw_pkg::TICK_MS_W];
                    end
                    csw_pkg::CFG_CLOCK_REDRAW: clock_redraw_reg <= cfg_data;
                    csw_pkg::CFG_SW_REDRAW:    sw_redraw_reg    <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_comb
    begin
        cfg.tick_period  = tick_period_reg;
        cfg.tick_ms      = tick_ms_reg;
        cfg.tick_us      = tick_us_reg;
        cfg.clock_redraw = clock_redraw_reg;
        cfg.sw_redraw    = sw_redraw_reg;
        cfg.busy         = split_pend_reg;
    end

endmodule

// ===== rtl/csw_stopwatch.sv =====
// ============================================================================
// csw_stopwatch
// Stopwatch counter in minutes, seconds, milliseconds and microseconds.
// ============================================================================
module csw_stopwatch (
    input  logic                              clk,
    input  logic                              rst_n,
    input  csw_pkg::csw_sw_ctrl_t             ctrl,
    input  logic [csw_pkg::TICK_MS_W-1:0]     tick_ms,
    input  logic [csw_pkg::SUB_MS_W-1:0]      tick_us,
    output csw_pkg::csw_sw_view_t             view
);

    logic       sw_run_reg,  sw_run_next;
    logic [5:0] sw_min_reg,  sw_min_next;
    logic [5:0] sw_sec_reg,  sw_sec_next;
    logic [9:0] sw_ms_reg,   sw_ms_next;
    logic [9:0] sw_us_reg,   sw_us_next;

    logic [10:0] us_sum;
    logic [10:0] us_wrap;
    logic        us_carry;
    logic [11:0] ms_sum;
    logic [11:0] ms_one;
    logic [11:0] ms_two;
    logic [1:0]  sec_step;
    logic [9:0]  ms_adv;
    logic [6:0]  sec_sum;
    logic [6:0]  sec_wrap;
    logic        min_carry;
    logic [6:0]  min_sum;

    always_comb
    begin
        us_sum   = {1'b0, sw_us_reg} + {1'b0, tick_us};
        us_wrap  = us_sum - 11'd1000;
        us_carry = (us_sum >= 11'd1000);

        ms_sum = {2'b0, sw_ms_reg} + {1'b0, tick_ms} + {11'd0, us_carry};
        ms_one = ms_sum - 12'd1000;
        ms_two = ms_sum - 12'd2000;
        if (ms_sum >= 12'd2000)
        begin
            sec_step = 2'd2;
            ms_adv   = ms_two[9:0];
        end
        else if (ms_sum >= 12'd1000)
        begin
            sec_step = 2'd1;
            ms_adv   = ms_one[9:0];
        end
        else
        begin
            sec_step = 2'd0;
            ms_adv   = ms_sum[9:0];
        end

        sec_sum   = {1'b0, sw_sec_reg} + {5'd0, sec_step};
        sec_wrap  = sec_sum - 7'd60;
        min_carry = (sec_sum >= 7'd60);
        min_sum   = {1'b0, sw_min_reg} + {6'd0, min_carry};

        sw_run_next = sw_run_reg;
        sw_min_next = sw_min_reg;
        sw_sec_next = sw_sec_reg;
        sw_ms_next  = sw_ms_reg;
        sw_us_next  = sw_us_reg;

        if (ctrl.tick && sw_run_reg)
        begin
            sw_us_next  = us_carry ? us_wrap[9:0] : us_sum[9:0];
            sw_ms_next  = ms_adv;
            sw_sec_next = min_carry ? sec_wrap[5:0] : sec_sum[5:0];
            // wrap at one hour
            sw_min_next = (min_sum >= 7'd60) ? 6'd0 : min_sum[5:0];
        end
        if (ctrl.toggle_run)
            sw_run_next = ~sw_run_reg;
        if (ctrl.clear)
        begin
            sw_min_next = '0;
            sw_sec_next = '0;
            sw_ms_next  = '0;
            sw_us_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_run_reg <= 1'b0;
            sw_min_reg <= '0;
            sw_sec_reg <= '0;
            sw_ms_reg  <= '0;
            sw_us_reg  <= '0;
        end
        else
        begin
            sw_run_reg <= sw_run_next;
            sw_min_reg <= sw_min_next;
            sw_sec_reg <= sw_sec_next;
            sw_ms_reg  <= sw_ms_next;
            sw_us_reg  <= sw_us_next;
        end
    end

    always_comb
    begin
        view.running = sw_run_next;
        view.minutes = sw_min_next;
        view.seconds = sw_sec_next;
        view.millis  = sw_ms_next;
    end

endmodule

// ===== rtl/csw_clock.sv =====
// ============================================================================
// csw_clock
// Time of day, run/mode flags, digit editor and redraw scheduling.
// ============================================================================
module csw_clock (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          fire,
    input  logic                          op,
    input  logic [csw_pkg::BTN_W-1:0]     buttons,
    input  csw_pkg::csw_cfg_t             cfg,
    output csw_pkg::csw_sw_ctrl_t         sw_ctrl,
    output csw_pkg::csw_clk_view_t        view
);

    logic        mode_reg,  mode_next;
    logic        run_reg,   run_next;
    logic [2:0]  cursor_reg, cursor_next;
    logic [4:0]  edit_hr_reg,  edit_hr_next;
    logic [5:0]  edit_min_reg, edit_min_next;
    logic [5:0]  edit_sec_reg, edit_sec_next;
    logic [4:0]  hr_reg,  hr_next;
    logic [5:0]  min_reg, min_next;
    logic [5:0]  sec_reg, sec_next;
    logic [19:0] us_reg,  us_next;
    // redraw mark minus clock time, in microseconds
    logic signed [csw_pkg::DIFF_W-1:0] diff_reg, diff_next;

    logic        is_tick, is_btn;
    logic [20:0] us_sum, us_one, us_two;
    logic [1:0]  sec_step;
    logic [19:0] us_adv;
    logic [6:0]  sec_sum, sec_wrap;
    logic        min_carry;
    logic [6:0]  min_sum;
    logic        hr_carry;
    logic [5:0]  hr_sum;
    logic        day_wrap;
    logic [4:0]  hr_adv;
    logic [5:0]  min_adv, sec_adv;

    logic [csw_pkg::TICK_W-1:0]        adv_amt;
    logic [csw_pkg::REDRAW_W-1:0]      interval;
    logic signed [24:0]                span;
    logic signed [csw_pkg::DIFF_W-1:0] d_dec, d_inc;
    logic                              tick_redraw;

    logic        run_new, load, cur_step, inc;
    logic [2:0]  cur1;
    logic [4:0]  eh0;
    logic [5:0]  em0, es0;
    logic [5:0]  h_tens, h_units, m_tens, m_units, s_tens, s_units;
    logic [4:0]  eh1;
    logic [5:0]  em1, es1;
    logic        redraw;

    always_comb
    begin
        is_tick = fire && (op == csw_pkg::OP_TICK);
        is_btn  = fire && (op == csw_pkg::OP_BUTTON) && (buttons != '0);

        // advance the time of day, at most two seconds of carry
        us_sum = {1'b0, us_reg} + {1'b0, cfg.tick_period};
        us_one = us_sum - csw_pkg::US_ONE_SEC;
        us_two = us_sum - csw_pkg::US_TWO_SEC;
        if (us_sum >= csw_pkg::US_TWO_SEC)
        begin
            sec_step = 2'd2;
            us_adv   = us_two[19:0];
        end
        else if (us_sum >= csw_pkg::US_ONE_SEC)
        begin
            sec_step = 2'd1;
            us_adv   = us_one[19:0];
        end
        else
        begin
            sec_step = 2'd0;
            us_adv   = us_sum[19:0];
        end
        sec_sum   = {1'b0, sec_reg} + {5'd0, sec_step};
        sec_wrap  = sec_sum - 7'd60;
        min_carry = (sec_sum >= 7'd60);
        sec_adv   = min_carry ? sec_wrap[5:0] : sec_sum[5:0];
        min_sum   = {1'b0, min_reg} + {6'd0, min_carry};
        hr_carry  = (min_sum >= 7'd60);
        min_adv   = hr_carry ? 6'd0 : min_sum[5:0];
        hr_sum    = {1'b0, hr_reg} + {5'd0, hr_carry};
        day_wrap  = (hr_sum >= 6'd24);
        hr_adv    = day_wrap ? 5'd0 : hr_sum[4:0];

        // redraw: both outcomes in parallel, pick by sign
        adv_amt  = run_reg ? cfg.tick_period : '0;
        interval = mode_reg ? cfg.sw_redraw : cfg.clock_redraw;
        span     = $signed({1'b0, interval}) - $signed({5'd0, adv_amt});
        if (run_reg && day_wrap)
        begin
            d_dec = '0;
            d_inc = $signed({14'd0, interval});
        end
        else
        begin
            d_dec = diff_reg - $signed({18'd0, adv_amt});
            d_inc = diff_reg + {{13{span[24]}}, span};
        end
        tick_redraw = d_dec[csw_pkg::DIFF_W-1] || (d_dec == '0);

        // clock-mode button chain
        run_new  = buttons[csw_pkg::BTN_RUN] ? ~run_reg : run_reg;
        load     = buttons[csw_pkg::BTN_RUN] && run_reg;
        cur_step = buttons[csw_pkg::BTN_NEXT] && !run_new;
        inc      = buttons[csw_pkg::BTN_INC] && !run_new;
        eh0      = load ? hr_reg  : edit_hr_reg;
        em0      = load ? min_reg : edit_min_reg;
        es0      = load ? sec_reg : edit_sec_reg;
        if (cur_step)
            cur1 = (cursor_reg >= csw_pkg::CUR_SEC_UNITS) ? csw_pkg::CUR_HOUR_TENS
                                                          : cursor_reg + 3'd1;
        else
            cur1 = cursor_reg;

        h_tens  = csw_pkg::bump_tens({1'b0, eh0}, 6'd24);
        h_units = csw_pkg::bump_units({1'b0, eh0}, 6'd24);
        m_tens  = csw_pkg::bump_tens(em0, 6'd60);
        m_units = csw_pkg::bump_units(em0, 6'd60);
        s_tens  = csw_pkg::bump_tens(es0, 6'd60);
        s_units = csw_pkg::bump_units(es0, 6'd60);
        eh1 = eh0;
        em1 = em0;
        es1 = es0;
        case (cur1)
            csw_pkg::CUR_HOUR_TENS:  eh1 = h_tens[4:0];
            csw_pkg::CUR_HOUR_UNITS: eh1 = h_units[4:0];
            csw_pkg::CUR_MIN_TENS:   em1 = m_tens;
            csw_pkg::CUR_MIN_UNITS:  em1 = m_units;
            csw_pkg::CUR_SEC_TENS:   es1 = s_tens;
            default:                 es1 = s_units;
        endcase

        // hold by default
        mode_next     = mode_reg;
        run_next      = run_reg;
        cursor_next   = cursor_reg;
        edit_hr_next  = edit_hr_reg;
        edit_min_next = edit_min_reg;
        edit_sec_next = edit_sec_reg;
        hr_next       = hr_reg;
        min_next      = min_reg;
        sec_next      = sec_reg;
        us_next       = us_reg;
        diff_next     = diff_reg;
        redraw        = 1'b0;
        sw_ctrl       = '0;

        if (is_tick)
        begin
            if (run_reg)
            begin
                hr_next  = hr_adv;
                min_next = min_adv;
                sec_next = sec_adv;
                us_next  = us_adv;
            end
            diff_next    = tick_redraw ? d_inc : d_dec;
            redraw       = tick_redraw;
            sw_ctrl.tick = mode_reg;
        end
        else if (is_btn)
        begin
            redraw = 1'b1;
            if (!mode_reg)
            begin
                if (buttons[csw_pkg::BTN_MODE] && run_reg)
                    mode_next = 1'b1;
                run_next      = run_new;
                cursor_next   = cur1;
                edit_hr_next  = inc ? eh1 : eh0;
                edit_min_next = inc ? em1 : em0;
                edit_sec_next = inc ? es1 : es0;
                if (inc)
                begin
                    // time becomes the edited whole seconds, mark follows
                    hr_next   = eh1;
                    min_next  = em1;
                    sec_next  = es1;
                    us_next   = '0;
                    diff_next = '0;
                end
            end
            else
            begin
                if (buttons[csw_pkg::BTN_MODE])
                    mode_next = 1'b0;
                sw_ctrl.toggle_run = buttons[csw_pkg::BTN_RUN];
                sw_ctrl.clear      = buttons[csw_pkg::BTN_NEXT];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= 1'b0;
            run_reg      <= 1'b0;
            cursor_reg   <= csw_pkg::CUR_HOUR_TENS;
            edit_hr_reg  <= '0;
            edit_min_reg <= '0;
            edit_sec_reg <= '0;
            hr_reg       <= '0;
            min_reg      <= '0;
            sec_reg      <= '0;
            us_reg       <= '0;
            diff_reg     <= '0;
        end
        else
        begin
            mode_reg     <= mode_next;
            run_reg      <= run_next;
            cursor_reg   <= cursor_next;
            edit_hr_reg  <= edit_hr_next;
            edit_min_reg <= edit_min_next;
            edit_sec_reg <= edit_sec_next;
            hr_reg       <= hr_next;
            min_reg      <= min_next;
            sec_reg      <= sec_next;
            us_reg       <= us_next;
            diff_reg     <= diff_next;
        end
    end

    always_comb
    begin
        view.mode          = mode_next;
        view.clock_running = run_next;
        view.hours         = run_next ? hr_next  : edit_hr_next;
        view.minutes       = run_next ? min_next : edit_min_next;
        view.seconds       = run_next ? sec_next : edit_sec_next;
        view.cursor        = cursor_next;
        view.redraw        = redraw;
    end

endmodule

// ===== rtl/clock_stopwatch_controller.sv =====
// ============================================================================
// clock_stopwatch_controller
// 24-hour clock with stopwatch, driven by tick and button items.
// ============================================================================
// Each input word is a tick (s_tuser = 0) or a button event (s_tuser = 1,
// mask in s_tdata[3:0]); every word yields exactly one result word. The block
// takes one word per cycle while m_tready and the tick split let it: a word
// waits in the input register, its whole effect is computed in a single pass
// and lands in the result register, from which it is offered on m_tvalid.
// While a finished result waits on m_tready, the input register still takes
// one more word and then holds s_tready low. Time of day is kept as
// hours/minutes/seconds plus microseconds and the stopwatch as
// minutes/seconds/milliseconds plus microseconds, so display fields need no
// division. The redraw mark is held as its distance from the clock time.
// Writing tick_period_us holds the pipeline while the period is split into
// milliseconds and a sub-millisecond remainder. Configuration must be
// written only while no word is in flight; the block itself does not
// enforce this.
// ============================================================================
module clock_stopwatch_controller (
    input  logic                                clk,
    input  logic                                rst_n,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [csw_pkg::IN_DATA_W-1:0]       s_tdata,   // [3:0] buttons_down, rest zero
    input  logic                                s_tuser,   // [0] op
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] mode, [1] clock_running, [2] stopwatch_running, [7:3] hours,
    // [13:8] minutes, [19:14] seconds, [25:20] sw_minutes, [31:26] sw_seconds,
    // [41:32] sw_millis, [44:42] cursor, [45] redraw, rest zero
    output logic [csw_pkg::OUT_DATA_W-1:0]      m_tdata,
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [csw_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [csw_pkg::CFG_DATA_W-1:0]      cfg_data
);

    csw_pkg::csw_cfg_t      cfg;
    csw_pkg::csw_sw_ctrl_t  sw_ctrl;
    csw_pkg::csw_sw_view_t  sw_view;
    csw_pkg::csw_clk_view_t clk_view;

    // input register
    logic                        in_valid_reg;
    logic                        in_op_reg;
    logic [csw_pkg::BTN_W-1:0]   in_btn_reg;

    // result register
    logic                        out_valid_reg;
    csw_pkg::csw_result_t        result_reg;
    csw_pkg::csw_result_t        result_next;

    logic fire;
    logic s_accept;

    // advance a word when the result slot frees and the tick split is settled
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready) && !cfg.busy;
    assign s_tready = !in_valid_reg || fire;
    assign s_accept = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = result_reg;

    csw_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    csw_clock u_clock (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .op      (in_op_reg),
        .buttons (in_btn_reg),
        .cfg     (cfg),
        .sw_ctrl (sw_ctrl),
        .view    (clk_view)
    );

    csw_stopwatch u_stopwatch (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (sw_ctrl),
        .tick_ms (cfg.tick_ms),
        .tick_us (cfg.tick_us),
        .view    (sw_view)
    );

    always_comb
    begin
        result_next.pad               = '0;
        result_next.redraw            = clk_view.redraw;
        result_next.cursor            = clk_view.cursor;
        result_next.sw_millis         = sw_view.millis;
        result_next.sw_seconds        = sw_view.seconds;
        result_next.sw_minutes        = sw_view.minutes;
        result_next.seconds           = clk_view.seconds;
        result_next.minutes           = clk_view.minutes;
        result_next.hours             = clk_view.hours;
        result_next.stopwatch_running = sw_view.running;
        result_next.clock_running     = clk_view.clock_running;
        result_next.mode              = clk_view.mode;
    end

    // control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_accept)
                in_valid_reg <= 1'b1;
            else if (fire)
                in_valid_reg <= 1'b0;

            if (fire)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_op_reg  <= s_tuser;
            in_btn_reg <= s_tdata[csw_pkg::BTN_W-1:0];
        end
        if (fire)
            result_reg <= result_next;
    end

    // a nonempty button event always asks for a redraw
    a_button_redraw: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (in_op_reg == csw_pkg::OP_BUTTON) && (in_btn_reg != '0)
        |=> m_tvalid && result_reg.redraw)
        else $error("button event without redraw");

    // a held input word is not lost or overwritten
    a_input_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !fire |=> in_valid_reg && $stable(in_btn_reg) && $stable(in_op_reg))
        else $error("input register overwritten");

    // displayed fields stay in their ranges
    a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (result_reg.hours < 5'd24) && (result_reg.minutes < 6'd60) &&
                     (result_reg.seconds < 6'd60) && (result_reg.sw_minutes < 6'd60) &&
                     (result_reg.sw_seconds < 6'd60) && (result_reg.sw_millis < 10'd1000) &&
                     (result_reg.cursor <= csw_pkg::CUR_SEC_UNITS))
        else $error("display field out of range");

    // no word moves while the tick split settles
    a_split_stall: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready && (cfg_index == csw_pkg::CFG_TICK_PERIOD) |=> !fire)
        else $error("word advanced during tick period split");

endmodule

// ===== dv/csw_checker.sv =====
// ============================================================================
// csw_checker
// Watches the streams of the clock/stopwatch block, tracks its expected
// display for every accepted word and compares each result word field by field.
// ============================================================================
module csw_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [csw_pkg::IN_DATA_W-1:0]   s_tdata,    // [3:0] buttons_down
    input  logic                            s_tuser,    // [0] op
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [csw_pkg::OUT_DATA_W-1:0]  m_tdata,    // csw_result_t layout
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [csw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [csw_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                              mismatches,
    output int                              words_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] DAY_US  = 64'd86400000000;
    localparam logic [63:0] HOUR_US = 64'd3600000000;
    localparam logic [63:0] SEC_US  = 64'd1000000;

    // register copies
    logic [csw_pkg::TICK_W-1:0]   tick_cfg;
    logic [csw_pkg::REDRAW_W-1:0] clock_redraw_cfg;
    logic [csw_pkg::REDRAW_W-1:0] sw_redraw_cfg;

    // tracked state of the clock and the stopwatch
    logic        sw_mode;
    logic        clock_run;
    logic        sw_run;
    logic [63:0] tod_us;
    logic [63:0] mark_us;
    logic [31:0] sw_us;
    logic [2:0]  cursor_pos;
    logic [4:0]  set_hours;
    logic [5:0]  set_minutes;
    logic [5:0]  set_seconds;

    csw_pkg::csw_result_t display_q[$];
    int                   results_seen;

    task automatic report_mismatch(input string what);
        $display("[%0t] display mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                      results_seen, name, got, want));
    endtask

    function automatic logic [5:0] tens_up(input logic [5:0] v, input logic [6:0] lim);
        logic [6:0] n;
        n = ({1'b0, v} + 7'd10) % lim;
        return n[5:0];
    endfunction

    // a units digit at nine falls back to zero within its tens
    function automatic logic [5:0] units_up(input logic [5:0] v, input logic [6:0] lim);
        logic [6:0] n;
        if (v % 6'd10 == 6'd9)
            return v - 6'd9;
        n = ({1'b0, v} + 7'd1) % lim;
        return n[5:0];
    endfunction

    // Apply one word to the tracked state and return the display it leaves.
    function automatic csw_pkg::csw_result_t step_display(input logic op,
                                                          input logic [3:0] btn);
        csw_pkg::csw_result_t r;
        logic                 redraw_now;
        logic [63:0]          t;
        logic [63:0]          secs;
        logic [5:0]           hr6;
        redraw_now = 1'b0;
        if (op == csw_pkg::OP_TICK)
        begin
            if (clock_run)
            begin
                tod_us = tod_us + {44'd0, tick_cfg};
                if (tod_us >= DAY_US)
                begin
                    tod_us  = tod_us - DAY_US;
                    mark_us = tod_us;
                end
            end
            if (sw_mode && sw_run)
            begin
                t = {32'd0, sw_us} + {44'd0, tick_cfg};
                if (t >= HOUR_US)
                    t = t - HOUR_US;
                sw_us = t[31:0];
            end
            if (mark_us <= tod_us)
            begin
                mark_us    = mark_us + {40'd0, sw_mode ? sw_redraw_cfg : clock_redraw_cfg};
                redraw_now = 1'b1;
            end
        end
        else if (btn != 4'd0)
        begin
            // later buttons keep the meaning of the mode the word began in
            if (!sw_mode)
            begin
                if (btn[csw_pkg::BTN_MODE] && clock_run)
                    sw_mode = 1'b1;
                if (btn[csw_pkg::BTN_RUN])
                begin
                    if (clock_run)
                    begin
                        clock_run   = 1'b0;
                        secs        = tod_us / SEC_US;
                        t           = secs % 64'd60;
                        set_seconds = t[5:0];
                        t           = (secs / 64'd60) % 64'd60;
                        set_minutes = t[5:0];
                        t           = (secs / 64'd3600) % 64'd24;
                        set_hours   = t[4:0];
                    end
                    else
                    begin
                        clock_run = 1'b1;
                    end
                end
                if (btn[csw_pkg::BTN_NEXT] && !clock_run)
                    cursor_pos = (cursor_pos == csw_pkg::CUR_SEC_UNITS)
                                 ? csw_pkg::CUR_HOUR_TENS : cursor_pos + 3'd1;
                if (btn[csw_pkg::BTN_INC] && !clock_run)
                begin
                    case (cursor_pos)
                        csw_pkg::CUR_HOUR_TENS:
                        begin
                            hr6       = tens_up({1'b0, set_hours}, 7'd24);
                            set_hours = hr6[4:0];
                        end
                        csw_pkg::CUR_HOUR_UNITS:
                        begin
                            hr6       = units_up({1'b0, set_hours}, 7'd24);
                            set_hours = hr6[4:0];
                        end
                        csw_pkg::CUR_MIN_TENS:  set_minutes = tens_up(set_minutes, 7'd60);
                        csw_pkg::CUR_MIN_UNITS: set_minutes = units_up(set_minutes, 7'd60);
                        csw_pkg::CUR_SEC_TENS:  set_seconds = tens_up(set_seconds, 7'd60);
                        default:                set_seconds = units_up(set_seconds, 7'd60);
                    endcase
                    // editing snaps the clock to whole seconds
                    tod_us = ({58'd0, set_seconds} + {58'd0, set_minutes} * 64'd60 +
                              {59'd0, set_hours} * 64'd3600) * SEC_US;
                    mark_us = tod_us;
                end
            end
            else
            begin
                if (btn[csw_pkg::BTN_MODE])
                    sw_mode = 1'b0;
                if (btn[csw_pkg::BTN_RUN])
                    sw_run = !sw_run;
                if (btn[csw_pkg::BTN_NEXT])
                    sw_us = 32'd0;
            end
            redraw_now = 1'b1;
        end

        r = '0;
        r.mode              = sw_mode;
        r.clock_running     = clock_run;
        r.stopwatch_running = sw_run;
        if (clock_run)
        begin
            secs      = tod_us / SEC_US;
            t         = secs % 64'd60;
            r.seconds = t[5:0];
            t         = (secs / 64'd60) % 64'd60;
            r.minutes = t[5:0];
            t         = (secs / 64'd3600) % 64'd24;
            r.hours   = t[4:0];
        end
        else
        begin
            r.hours   = set_hours;
            r.minutes = set_minutes;
            r.seconds = set_seconds;
        end
        secs         = {32'd0, sw_us} / SEC_US;
        t            = (secs / 64'd60) % 64'd60;
        r.sw_minutes = t[5:0];
        t            = secs % 64'd60;
        r.sw_seconds = t[5:0];
        t            = ({32'd0, sw_us} / 64'd1000) % 64'd1000;
        r.sw_millis  = t[9:0];
        r.cursor     = cursor_pos;
        r.redraw     = redraw_now;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        csw_pkg::csw_result_t want;
        csw_pkg::csw_result_t got;
        if (!rst_n)
        begin
            tick_cfg         = csw_pkg::TICK_PERIOD_RESET;
            clock_redraw_cfg = csw_pkg::CLOCK_REDRAW_RESET;
            sw_redraw_cfg    = csw_pkg::SW_REDRAW_RESET;
            sw_mode          = 1'b0;
            clock_run        = 1'b0;
            sw_run           = 1'b0;
            tod_us           = '0;
            mark_us          = '0;
            sw_us            = '0;
            cursor_pos       = csw_pkg::CUR_HOUR_TENS;
            set_hours        = '0;
            set_minutes      = '0;
            set_seconds      = '0;
            display_q.delete();
            words_owed      <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    csw_pkg::CFG_TICK_PERIOD:  tick_cfg = cfg_data[csw_pkg::TICK_W-1:0];
                    csw_pkg::CFG_CLOCK_REDRAW: clock_redraw_cfg = cfg_data;
                    csw_pkg::CFG_SW_REDRAW:    sw_redraw_cfg = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                display_q.push_back(step_display(s_tuser, s_tdata[csw_pkg::BTN_W-1:0]));
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (display_q.size() == 0)
                begin
                    report_mismatch($sformatf("result %0d arrived with none pending",
                                              results_seen));
                end
                else
                begin
                    want = display_q.pop_front();
                    got  = m_tdata;
                    check_field("mode", 16'(got.mode), 16'(want.mode));
                    check_field("clock_running", 16'(got.clock_running),
                                16'(want.clock_running));
                    check_field("stopwatch_running", 16'(got.stopwatch_running),
                                16'(want.stopwatch_running));
                    check_field("hours", 16'(got.hours), 16'(want.hours));
                    check_field("minutes", 16'(got.minutes), 16'(want.minutes));
                    check_field("seconds", 16'(got.seconds), 16'(want.seconds));
                    check_field("sw_minutes", 16'(got.sw_minutes), 16'(want.sw_minutes));
                    check_field("sw_seconds", 16'(got.sw_seconds), 16'(want.sw_seconds));
                    check_field("sw_millis", 16'(got.sw_millis), 16'(want.sw_millis));
                    check_field("cursor", 16'(got.cursor), 16'(want.cursor));
                    check_field("redraw", 16'(got.redraw), 16'(want.redraw));
                    check_field("padding", 16'(got.pad), 16'(want.pad));
                end
            end
            words_owed <= display_q.size();
        end
    end

endmodule

// ===== dv/clock_stopwatch_controller_tb.sv =====
// ============================================================================
// clock_stopwatch_controller_tb
// Drives ticks and button events into the clock/stopwatch block: a directed
// walk through editing and mode changes, a tick soak that wraps the day, then
// random phases under several register settings and stall patterns. A checker
// beside the block does the predicting.
// ============================================================================
module clock_stopwatch_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // button masks, one bit per button
    localparam logic [csw_pkg::BTN_W-1:0] PRESS_NONE = '0;
    localparam logic [csw_pkg::BTN_W-1:0] PRESS_MODE = 4'b0001 << csw_pkg::BTN_MODE;
    localparam logic [csw_pkg::BTN_W-1:0] PRESS_RUN  = 4'b0001 << csw_pkg::BTN_RUN;
    localparam logic [csw_pkg::BTN_W-1:0] PRESS_NEXT = 4'b0001 << csw_pkg::BTN_NEXT;
    localparam logic [csw_pkg::BTN_W-1:0] PRESS_INC  = 4'b0001 << csw_pkg::BTN_INC;
    localparam logic [csw_pkg::BTN_W-1:0] PRESS_ALL  = '1;

    localparam int SETTLE_CYCLES   = 4;
    localparam int TAIL_CYCLES     = 8;
    localparam int SOAK_TICKS      = 700;   // past midnight from 23:50 at one second per tick
    localparam int PHASES          = 6;
    localparam int WORDS_PER_PHASE = 58;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    logic [csw_pkg::IN_DATA_W-1:0]    s_tdata   = '0;
    logic                             s_tuser   = 1'b0;
    logic                             m_tvalid;
    logic                             m_tready  = 1'b0;
    logic [csw_pkg::OUT_DATA_W-1:0]   m_tdata;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [csw_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
    logic [csw_pkg::CFG_DATA_W-1:0]   cfg_data  = '0;

    int mismatches;
    int owed;

    // stall odds in percent, changed between phases
    int src_idle_pct = 22;
    int snk_idle_pct = 47;

    always #1 clk = ~clk;

    clock_stopwatch_controller dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    csw_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .words_owed (owed)
    );

    // Stall the result side at random; a zero percentage keeps ready high.
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= snk_idle_pct);

    // Offer one word, idling first at random, and hold it until taken.
    task automatic push_word(input logic op, input logic [csw_pkg::BTN_W-1:0] btn);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(csw_pkg::IN_DATA_W-csw_pkg::BTN_W){1'b0}}, btn};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Drop valid, wait for every pending result, then let the pipe empty.
    task automatic settle(input int extra);
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (owed != 0)
            @(negedge clk);
        repeat (extra) @(negedge clk);
    endtask

    task automatic write_reg(input logic [csw_pkg::CFG_IDX_W-1:0] idx,
                             input int unsigned val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[csw_pkg::CFG_DATA_W-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Call only with the block drained.
    task automatic program_regs(input int unsigned tick, input int unsigned clk_iv,
                                input int unsigned sw_iv);
        write_reg(csw_pkg::CFG_TICK_PERIOD, tick);
        write_reg(csw_pkg::CFG_CLOCK_REDRAW, clk_iv);
        write_reg(csw_pkg::CFG_SW_REDRAW, sw_iv);
    endtask

    // One random stimulus step: mostly ticks and single presses, some raw masks
    // (empty ones included) and short edit bursts that move the cursor and
    // bump digits.
    task automatic random_word();
        logic [31:0]               rnd;
        logic [csw_pkg::BTN_W-1:0] b;
        int                        pick;
        rnd  = $urandom;
        pick = $urandom_range(99);
        if (pick == 0)
            settle(0);  // hold off until all results are back
        if (pick < 45)
        begin
            push_word(csw_pkg::OP_TICK, rnd[csw_pkg::BTN_W-1:0]);
        end
        else if (pick < 75)
        begin
            push_word(csw_pkg::OP_BUTTON, PRESS_MODE << rnd[1:0]);
        end
        else if (pick < 90)
        begin
            push_word(csw_pkg::OP_BUTTON, rnd[csw_pkg::BTN_W-1:0]);
        end
        else
        begin
            repeat (6)
            begin
                rnd = $urandom;
                case (rnd[1:0])
                    2'd0:    b = PRESS_NEXT;
                    2'd3:    b = PRESS_NEXT | PRESS_INC;
                    default: b = PRESS_INC;
                endcase
                push_word(csw_pkg::OP_BUTTON, b);
            end
        end
    endtask

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // Directed walk at reset settings. The clock starts paused at zero
        // with the cursor on the tens of hours.
        push_word(csw_pkg::OP_TICK, PRESS_NONE);     // frozen time still meets the mark
        push_word(csw_pkg::OP_TICK, PRESS_ALL);      // buttons on a tick are ignored
        push_word(csw_pkg::OP_BUTTON, PRESS_NONE);   // empty event: no change, no redraw
        push_word(csw_pkg::OP_BUTTON, PRESS_MODE);   // no stopwatch while paused
        push_word(csw_pkg::OP_BUTTON, PRESS_INC);    // 10 h
        push_word(csw_pkg::OP_BUTTON, PRESS_INC);    // 20 h
        push_word(csw_pkg::OP_BUTTON, PRESS_NEXT | PRESS_INC);  // cursor to units, 21 h
        push_word(csw_pkg::OP_BUTTON, PRESS_INC);
        push_word(csw_pkg::OP_BUTTON, PRESS_INC);    // 23 h
        push_word(csw_pkg::OP_BUTTON, PRESS_NEXT | PRESS_INC);  // tens of minutes, 10 min
        repeat (4) push_word(csw_pkg::OP_BUTTON, PRESS_INC);    // 50 min
        push_word(csw_pkg::OP_BUTTON, PRESS_RUN);    // start the clock at 23:50
        push_word(csw_pkg::OP_TICK, PRESS_NONE);
        push_word(csw_pkg::OP_BUTTON, PRESS_NEXT | PRESS_INC);  // ignored while running
        // mode switch and pause in one word: run still acts as in clock mode
        push_word(csw_pkg::OP_BUTTON, PRESS_MODE | PRESS_RUN);
        push_word(csw_pkg::OP_BUTTON, PRESS_RUN);    // start the stopwatch
        push_word(csw_pkg::OP_TICK, PRESS_NONE);
        push_word(csw_pkg::OP_BUTTON, PRESS_INC);    // no effect in stopwatch mode
        push_word(csw_pkg::OP_BUTTON, PRESS_NEXT);   // clear
        push_word(csw_pkg::OP_BUTTON, PRESS_ALL);    // back to clock, stop, clear
        push_word(csw_pkg::OP_BUTTON, PRESS_RUN);    // clock runs again from 23:50
        push_word(csw_pkg::OP_BUTTON, PRESS_MODE);
        push_word(csw_pkg::OP_BUTTON, PRESS_RUN);
        push_word(csw_pkg::OP_TICK, PRESS_NONE);

        // Soak at one second per tick: the day wraps past midnight while the
        // stopwatch runs, redraw firing on every tick.
        settle(SETTLE_CYCLES);
        program_regs(1000000, 10000000, 1);
        repeat (SOAK_TICKS) push_word(csw_pkg::OP_TICK, 4'($urandom_range(15)));

        for (int p = 0; p < PHASES; p++)
        begin
            settle(SETTLE_CYCLES);
            case (p / 2)
                0:
                begin
                    src_idle_pct = 22;
                    snk_idle_pct = 47;
                end
                1:
                begin
                    src_idle_pct = 47;
                    snk_idle_pct = 22;
                end
                default:
                begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
            endcase
            case (p)
                0: program_regs(1000000, 1, 1);
                1: program_regs(0, 0, 0);   // frozen ticks, zero redraw intervals
                2: program_regs(1, 10000000, 10000000);
                3: program_regs($urandom_range(1000000, 1), $urandom_range(10000000, 1),
                                $urandom_range(10000000, 1));
                4: program_regs(32'(csw_pkg::TICK_PERIOD_RESET),
                                32'(csw_pkg::CLOCK_REDRAW_RESET),
                                32'(csw_pkg::SW_REDRAW_RESET));
                default: program_regs($urandom_range(200000, 1000),
                                      $urandom_range(5000000, 1),
                                      $urandom_range(500000, 1));
            endcase
            repeat (WORDS_PER_PHASE) random_word();
        end

        settle(TAIL_CYCLES);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #1000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/csw_pkg.sv
rtl/csw_cfg.sv
rtl/csw_stopwatch.sv
rtl/csw_clock.sv
rtl/clock_stopwatch_controller.sv
dv/csw_checker.sv
dv/clock_stopwatch_controller_tb.sv
